@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file, nptw_checker.sv.
// Depends on nothing; take it in by `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPTW_ASSERT_SAME(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("nptw same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define NPTW_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("nptw next-cycle check failed");

`endif

@@ hw/rtl/nptw_pkg.sv @@
// Package for the nested page table walker: codes, widths, command and status types.
// Depends on nothing; used by every module of the walker except nptw_ram.
package nptw_pkg;

    localparam int DEFAULT_SLOT_COUNT = 16;

    localparam int FRAME_W = 52;
    localparam int END_W   = 53;
    localparam int ADDR_W  = 64;
    localparam int ENTRY_W = ADDR_W + END_W + FRAME_W;

    localparam logic [ADDR_W-1:0] FRAME_MASK = 64'h0FFF_FFFF_FFFF_F000;

    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] LEVEL_LAST = 2'd3;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_RESP  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic write;
        logic begin_walk;
        logic begin_step;
        logic scan_next;
        logic latch_hit;
        logic sum;
        logic emit_req;
        logic emit_leaf;
        logic emit_miss;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic resp_ok;
        logic level_last;
        logic hit;
        logic scan_last;
    } status_t;

    function automatic logic [8:0] table_index(logic [ADDR_W-1:0] va, logic [1:0] lvl);
        logic [8:0] idx;
        case (lvl)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

@@ hw/rtl/nptw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/nptw_ctrl.sv @@
// Walk controller: sequences slot writes, slot scans, address sums and result transfers.
// Depends on nptw_pkg; drives the datapath through cmd_t and reads status_t.
module nptw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  nptw_pkg::status_t  status,
    output nptw_pkg::cmd_t     cmd,
    output logic               busy
);

    import nptw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_WRITE:
                        begin
                            cmd.write = 1'b1;
                        end
                        ACT_START:
                        begin
                            cmd.begin_walk = 1'b1;
                            state_next     = ST_READ;
                        end
                        ACT_RESP:
                        begin
                            if (status.active)
                            begin
                                if (!status.resp_ok)
                                begin
                                    cmd.emit_miss = 1'b1;
                                end
                                else if (status.level_last)
                                begin
                                    cmd.emit_leaf = 1'b1;
                                end
                                else
                                begin
                                    cmd.begin_step = 1'b1;
                                    state_next     = ST_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (status.hit)
                begin
                    cmd.latch_hit = 1'b1;
                    state_next    = ST_SUM;
                end
                else if (status.scan_last)
                begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit_req = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hw/rtl/nptw_dp.sv @@
// Walk datapath: slot table RAM with valid bits, walk registers, range compare, result registers.
// Depends on nptw_pkg and nptw_ram; commanded by nptw_ctrl.
module nptw_dp #(
    parameter int SLOT_COUNT = nptw_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nptw_pkg::cmd_t    cmd,
    output nptw_pkg::status_t status,
    input  logic [3:0]        slot_index,
    input  logic [51:0]       slot_base_frame,
    input  logic [51:0]       slot_page_count,
    input  logic [63:0]       slot_host_base,
    input  logic [63:0]       walk_root,
    input  logic [63:0]       walk_address,
    input  logic [63:0]       read_data,
    input  logic              read_error,
    output logic              result_valid,
    output logic              result_kind,
    output logic [63:0]       read_address,
    output logic [63:0]       leaf_entry,
    output logic              mapped
);

    import nptw_pkg::*;

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [6:0]    SLOT_LIMIT = 7'(SLOT_COUNT);
    localparam logic [AW-1:0] SLOT_LAST  = AW'(SLOT_COUNT - 1);

    logic [SLOT_COUNT-1:0] valid_reg;
    logic                  active_reg;
    logic [1:0]            level_reg;
    logic [AW-1:0]         scan_idx_reg;
    logic                  result_valid_reg;

    logic [ADDR_W-1:0]     target_reg;
    logic [ADDR_W-1:0]     gpa_reg;
    logic [ADDR_W-1:0]     off_reg;
    logic [ADDR_W-1:0]     hostb_reg;
    logic [ADDR_W-1:0]     sum_reg;
    logic                  kind_reg;
    logic [ADDR_W-1:0]     read_address_reg;
    logic [ADDR_W-1:0]     leaf_reg;
    logic                  mapped_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [END_W-1:0]      wr_end;
    logic [ENTRY_W-1:0]    rd_data;
    logic [FRAME_W-1:0]    rd_base;
    logic [END_W-1:0]      rd_end;
    logic [ADDR_W-1:0]     rd_host;
    logic [FRAME_W-1:0]    frame;
    logic [ADDR_W-1:0]     req_offset;
    logic                  finish;

    assign wr_en   = cmd.write && ({3'b000, slot_index} < SLOT_LIMIT);
    assign wr_addr = AW'(slot_index);
    assign wr_end  = {1'b0, slot_base_frame} + {1'b0, slot_page_count};
    assign wr_data = {slot_host_base, wr_end, slot_base_frame};

    nptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_base = rd_data[FRAME_W-1:0];
    assign rd_end  = rd_data[FRAME_W+END_W-1:FRAME_W];
    assign rd_host = rd_data[ENTRY_W-1:FRAME_W+END_W];
    assign frame   = gpa_reg[ADDR_W-1:12];

    assign status.active     = active_reg;
    assign status.resp_ok    = !read_error && read_data[0];
    assign status.level_last = (level_reg == LEVEL_LAST);
    assign status.hit        = valid_reg[scan_idx_reg] && (frame >= rd_base)
                               && ({1'b0, frame} < rd_end);
    assign status.scan_last  = (scan_idx_reg == SLOT_LAST);

    assign req_offset = {52'd0, table_index(target_reg, level_reg), 3'b000};
    assign finish     = cmd.emit_miss || cmd.emit_leaf;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            active_reg       <= 1'b0;
            level_reg        <= 2'd0;
            scan_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.begin_walk)
            begin
                active_reg <= 1'b1;
                level_reg  <= 2'd0;
            end
            else if (cmd.begin_step)
            begin
                level_reg <= level_reg + 2'd1;
            end
            else if (finish)
            begin
                active_reg <= 1'b0;
                level_reg  <= 2'd0;
            end
            if (cmd.begin_walk || cmd.begin_step)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_next)
            begin
                scan_idx_reg <= scan_idx_reg + AW'(1);
            end
            result_valid_reg <= cmd.emit_req || finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_walk)
        begin
            target_reg <= walk_address;
            gpa_reg    <= walk_root;
        end
        else if (cmd.begin_step)
        begin
            gpa_reg <= read_data & FRAME_MASK;
        end
        if (cmd.latch_hit)
        begin
            off_reg   <= gpa_reg - {rd_base, 12'h000};
            hostb_reg <= rd_host;
        end
        if (cmd.sum)
        begin
            sum_reg <= hostb_reg + off_reg;
        end
        if (cmd.emit_req)
        begin
            kind_reg         <= KIND_REQ;
            read_address_reg <= sum_reg + req_offset;
            leaf_reg         <= '0;
            mapped_reg       <= 1'b0;
        end
        else if (cmd.emit_leaf)
        begin
            kind_reg         <= KIND_DONE;
            read_address_reg <= '0;
            leaf_reg         <= read_data;
            mapped_reg       <= 1'b1;
        end
        else if (cmd.emit_miss)
        begin
            kind_reg         <= KIND_DONE;
            read_address_reg <= '0;
            leaf_reg         <= '0;
            mapped_reg       <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = kind_reg;
    assign read_address = read_address_reg;
    assign leaf_entry   = leaf_reg;
    assign mapped       = mapped_reg;

endmodule

@@ hw/rtl/nested_page_table_walker.sv @@
// Top level of the nested page table walker.
// Depends on nptw_pkg, nptw_ctrl, nptw_dp and nptw_ram.
//
// Usage: one command channel in, one result channel out.
// A command is a transfer at a clock edge with start high and busy low; action selects it:
//   slot write (slot_index, slot_base_frame, slot_page_count, slot_host_base) gives no
//   result and leaves busy low;
//   walk start (walk_root, walk_address) translates the root through the slot table;
//   read response (read_data, read_error) either ends the walk or issues the next read.
// Every result is shown for one cycle with result_valid high, the cycle after the
// block decides it; the receiver cannot stall, so nothing is held back.
// A finish decided from a read response alone needs no slot scan. A translation scans
// the slot table through its single RAM read port, slot by slot in slot order, and
// stops at the first hit, which yields a read request; a miss ends the walk once every
// slot has been scanned. busy is high during the scan and falls as the result is shown,
// so the next command can be taken in the result cycle.
// Reset (rst_n low, asynchronous) disables every slot and ends any walk;
// a read response with no walk running is dropped.
module nested_page_table_walker #(
    parameter int SLOT_COUNT = nptw_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [3:0]  slot_index,
    input  logic [51:0] slot_base_frame,
    input  logic [51:0] slot_page_count,
    input  logic [63:0] slot_host_base,
    input  logic [63:0] walk_root,
    input  logic [63:0] walk_address,
    input  logic [63:0] read_data,
    input  logic        read_error,
    output logic        result_valid,
    output logic        result_kind,
    output logic [63:0] read_address,
    output logic [63:0] leaf_entry,
    output logic        mapped
);

    import nptw_pkg::*;

    cmd_t    cmd;
    status_t status;

    nptw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    nptw_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .slot_index      (slot_index),
        .slot_base_frame (slot_base_frame),
        .slot_page_count (slot_page_count),
        .slot_host_base  (slot_host_base),
        .walk_root       (walk_root),
        .walk_address    (walk_address),
        .read_data       (read_data),
        .read_error      (read_error),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .read_address    (read_address),
        .leaf_entry      (leaf_entry),
        .mapped          (mapped)
    );

endmodule

@@ hw/rtl/nptw_checker.sv @@
// Port-level checks for the nested page table walker, bound to the top level.
// Depends on nptw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nptw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  action,
    input logic        result_valid,
    input logic        result_kind,
    input logic [63:0] read_address,
    input logic [63:0] leaf_entry,
    input logic        mapped
);

    import nptw_pkg::*;

    `NPTW_ASSERT_SAME(a_done_no_addr, clk, rst_n, result_valid && (result_kind == KIND_DONE), read_address == 64'd0)
    `NPTW_ASSERT_SAME(a_req_no_leaf, clk, rst_n, result_valid && (result_kind == KIND_REQ), (leaf_entry == 64'd0) && !mapped)
    `NPTW_ASSERT_SAME(a_mapped_present, clk, rst_n, result_valid && mapped, (result_kind == KIND_DONE) && leaf_entry[0])
    `NPTW_ASSERT_NEXT(a_start_scans, clk, rst_n, start && !busy && (action == ACT_START), busy && !result_valid)

endmodule

bind nested_page_table_walker nptw_checker u_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for nested_page_table_walker: slot writes, walk starts and read
// responses go in over the command port; each result is checked against a predictor.
// Depends on nptw_pkg and the walker RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nptw_pkg::*;

    localparam int SLOTS = DEFAULT_SLOT_COUNT;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam logic [63:0] TABLE_SPACE = 64'h0001_0000_0000_0000;

    typedef struct {
        action_t     act;
        logic [3:0]  idx;
        logic [51:0] base;
        logic [51:0] pages;
        logic [63:0] host;
        logic [63:0] root;
        logic [63:0] va;
        logic [63:0] data;
        logic        err;
    } walker_cmd_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] addr;
        logic [63:0] leaf;
        logic        mapped;
    } walk_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    action_t     action;
    logic [3:0]  slot_index;
    logic [51:0] slot_base_frame;
    logic [51:0] slot_page_count;
    logic [63:0] slot_host_base;
    logic [63:0] walk_root;
    logic [63:0] walk_address;
    logic [63:0] read_data;
    logic        read_error;
    logic        result_valid;
    logic        result_kind;
    logic [63:0] read_address;
    logic [63:0] leaf_entry;
    logic        mapped;

    logic [51:0] exp_slot_base [SLOTS];
    logic [51:0] exp_slot_pages [SLOTS];
    logic [63:0] exp_slot_host [SLOTS];
    logic        exp_walking;
    logic [1:0]  exp_depth;
    logic [63:0] exp_va;

    walk_result_t pending_results[$];
    int error_count;
    int counted_items;
    int stall_cycles;
    bit no_gaps;

    nested_page_table_walker uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .slot_index      (slot_index),
        .slot_base_frame (slot_base_frame),
        .slot_page_count (slot_page_count),
        .slot_host_base  (slot_host_base),
        .walk_root       (walk_root),
        .walk_address    (walk_address),
        .read_data       (read_data),
        .read_error      (read_error),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .read_address    (read_address),
        .leaf_entry      (leaf_entry),
        .mapped          (mapped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic walker_cmd_t random_cmd(action_t a);
        walker_cmd_t c;
        logic [63:0] w;
        c.act = a;
        c.idx = 4'($urandom_range(0, 15));
        w = rand64();
        c.base = w[51:0];
        w = rand64();
        c.pages = w[51:0];
        c.host = rand64();
        c.root = rand64();
        c.va = rand64();
        c.data = rand64();
        c.err = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic bit slot_lookup(input logic [63:0] gpa, output logic [63:0] host_addr);
        logic [52:0] frame;
        logic [52:0] top;
        host_addr = '0;
        frame = {1'b0, gpa[63:12]};
        for (int i = 0; i < SLOTS; i++)
        begin
            top = {1'b0, exp_slot_base[i]} + {1'b0, exp_slot_pages[i]};
            if (frame >= {1'b0, exp_slot_base[i]} && frame < top)
            begin
                host_addr = exp_slot_host[i] + (gpa - {exp_slot_base[i], 12'h000});
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic walk_result_t read_request(logic [63:0] table_host);
        walk_result_t r;
        logic [63:0] shifted;
        shifted = exp_va >> (39 - 9 * int'(exp_depth));
        r.kind = KIND_REQ;
        r.addr = table_host + {52'h0, shifted[8:0], 3'b000};
        r.leaf = '0;
        r.mapped = 1'b0;
        return r;
    endfunction

    function automatic walk_result_t walk_done(logic [63:0] pte, logic hit);
        walk_result_t r;
        exp_walking = 1'b0;
        exp_depth = '0;
        r.kind = KIND_DONE;
        r.addr = '0;
        r.leaf = hit ? pte : '0;
        r.mapped = hit;
        return r;
    endfunction

    // Returns 1 when the item does something, 0 when the block drops it.
    function automatic bit predict_walker(walker_cmd_t c);
        logic [63:0] host_addr;
        case (c.act)
            ACT_WRITE:
            begin
                exp_slot_base[c.idx] = c.base;
                exp_slot_pages[c.idx] = c.pages;
                exp_slot_host[c.idx] = c.host;
                return 1'b1;
            end
            ACT_START:
            begin
                exp_va = c.va;
                exp_depth = '0;
                exp_walking = 1'b1;
                if (!slot_lookup(c.root, host_addr))
                    pending_results.push_back(walk_done('0, 1'b0));
                else
                    pending_results.push_back(read_request(host_addr));
                return 1'b1;
            end
            ACT_RESP:
            begin
                if (!exp_walking)
                    return 1'b0;
                if (c.err || !c.data[0])
                    pending_results.push_back(walk_done('0, 1'b0));
                else if (exp_depth == LEVEL_LAST)
                    pending_results.push_back(walk_done(c.data, 1'b1));
                else if (!slot_lookup(c.data & FRAME_MASK, host_addr))
                    pending_results.push_back(walk_done('0, 1'b0));
                else
                begin
                    exp_depth = exp_depth + 2'd1;
                    pending_results.push_back(read_request(host_addr));
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [47:0] pick_table_frame();
        logic [63:0] span;
        int k;
        for (int n = 0; n < 32; n++)
        begin
            k = $urandom_range(0, SLOTS - 1);
            if (exp_slot_pages[k] != '0 && 64'(exp_slot_base[k]) < TABLE_SPACE)
            begin
                span = 64'(exp_slot_pages[k]);
                if (64'(exp_slot_base[k]) + span > TABLE_SPACE)
                    span = TABLE_SPACE - 64'(exp_slot_base[k]);
                return 48'(64'(exp_slot_base[k]) + rand64() % span);
            end
        end
        return 48'(rand64());
    endfunction

    function automatic logic [63:0] pick_root_gpa();
        logic [63:0] frame;
        logic [63:0] w;
        int k;
        w = rand64();
        for (int n = 0; n < 32; n++)
        begin
            k = $urandom_range(0, SLOTS - 1);
            if (exp_slot_pages[k] != '0)
            begin
                frame = 64'(exp_slot_base[k]) + rand64() % 64'(exp_slot_pages[k]);
                return {frame[51:0], w[11:0]};
            end
        end
        return w;
    endfunction

    task automatic send_item(walker_cmd_t c);
        if (!no_gaps && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        action <= c.act;
        slot_index <= c.idx;
        slot_base_frame <= c.base;
        slot_page_count <= c.pages;
        slot_host_base <= c.host;
        walk_root <= c.root;
        walk_address <= c.va;
        read_data <= c.data;
        read_error <= c.err;
        do @(posedge clk); while (busy);
        if (predict_walker(c))
            counted_items++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic send_write(int idx, logic [51:0] base, logic [51:0] pages, logic [63:0] host);
        walker_cmd_t c;
        c = random_cmd(ACT_WRITE);
        c.idx = 4'(idx);
        c.base = base;
        c.pages = pages;
        c.host = host;
        send_item(c);
    endtask

    task automatic send_start(logic [63:0] root, logic [63:0] va);
        walker_cmd_t c;
        c = random_cmd(ACT_START);
        c.root = root;
        c.va = va;
        send_item(c);
    endtask

    task automatic send_response(logic [63:0] data, logic err);
        walker_cmd_t c;
        c = random_cmd(ACT_RESP);
        c.data = data;
        c.err = err;
        send_item(c);
    endtask

    task automatic test_idle_and_root_miss();
        walker_cmd_t c;
        send_start(64'h0, '1);
        send_response('1, 1'b0);
        c = random_cmd(ACT_NONE);
        send_item(c);
        send_response(64'h0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_slot_extremes();
        send_write(15, '1, '1, '1);
        send_start('1, '1);
        send_response('1, 1'b1);
        send_write(0, '0, 52'h1, 64'h0);
        send_start(64'h0, 64'h0);
        send_response(64'h0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_full_walk();
        send_write(1, 52'h100, 52'h10, 64'hFFFF_8000_0000_0000);
        send_start(64'h0000_0000_0010_0000, 64'h0000_7F80_4020_1000);
        send_response(64'h0000_0000_0010_1003, 1'b0);
        send_response(64'hF000_0000_0010_2FFF, 1'b0);
        send_response(64'h0000_0000_0010_F001, 1'b0);
        send_response(64'h8000_0000_DEAD_B001, 1'b0);
        send_start(64'h0000_0000_0010_5000, 64'h0);
        send_response(64'h0000_0000_0500_0001, 1'b0);
        wait_for_results();
    endtask

    task automatic test_walk_abort();
        send_start(64'h0000_0000_0010_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_response(64'h0000_0000_0010_1001, 1'b0);
        send_start(64'h0000_0000_0010_3ABC, 64'h0000_5555_AAAA_5000);
        send_write(2, 52'h200, 52'h4, 64'h0000_1234_0000_0000);
        send_response(64'h0000_0000_0020_3001, 1'b0);
        send_response(64'h0000_0000_0010_4001, 1'b0);
        send_response(64'h0000_0000_0020_0001, 1'b0);
        send_response(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        wait_for_results();
    endtask

    task automatic load_random_slot_map();
        walker_cmd_t c;
        int roll;
        for (int i = 0; i < SLOTS; i++)
        begin
            c = random_cmd(ACT_WRITE);
            c.idx = 4'(i);
            roll = $urandom_range(0, 99);
            if (roll < 12)
                c.pages = '0;
            else if (roll < 85)
            begin
                c.base = {16'h0, c.base[35:0]};
                c.pages = 52'($urandom_range(1, 512));
            end
            send_item(c);
        end
    endtask

    task automatic run_one_walk();
        walker_cmd_t c;
        int roll;
        c = random_cmd(ACT_START);
        if ($urandom_range(0, 19) != 0)
            c.root = pick_root_gpa();
        send_item(c);
        for (int lvl = 0; lvl < 4 && exp_walking; lvl++)
        begin
            c = random_cmd(ACT_RESP);
            c.err = 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                return;
            else if (roll < 5)
                c.err = 1'b1;
            else if (roll < 8)
                c.data[0] = 1'b0;
            else if (lvl == 3)
                c.data[0] = 1'b1;
            else if (roll < 10)
                c.data[0] = 1'b1;
            else
            begin
                c.data[59:12] = pick_table_frame();
                c.data[0] = 1'b1;
            end
            send_item(c);
        end
    endtask

    task automatic test_random_walks();
        walker_cmd_t c;
        int first;
        int roll;
        first = counted_items;
        load_random_slot_map();
        while (counted_items - first < RANDOM_ITEMS)
        begin
            no_gaps = (counted_items - first >= 700) && (counted_items - first < 1000);
            roll = $urandom_range(0, 99);
            if (roll < 3)
                load_random_slot_map();
            else if (roll < 85)
                run_one_walk();
            else if (roll < 93)
                send_item(random_cmd(ACT_RESP));
            else
            begin
                c = random_cmd(action_t'($urandom_range(0, 3)));
                send_item(c);
            end
            if ($urandom_range(0, 149) == 0)
                wait_for_results();
        end
        no_gaps = 1'b0;
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(negedge clk)
    begin : check_result
        walk_result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual kind %b address %h leaf %h mapped %b",
                         $time, result_kind, read_address, leaf_entry, mapped);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(result_kind));
                check_field("read_address", want.addr, read_address);
                check_field("leaf_entry", want.leaf, leaf_entry);
                check_field("mapped", 64'(want.mapped), 64'(mapped));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid === 1'b1)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, stall_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        counted_items = 0;
        no_gaps = 1'b0;
        exp_walking = 1'b0;
        exp_depth = '0;
        exp_va = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            exp_slot_base[i] = '0;
            exp_slot_pages[i] = '0;
            exp_slot_host[i] = '0;
        end
        rst_n <= 1'b0;
        start <= 1'b0;
        action <= ACT_NONE;
        slot_index <= '0;
        slot_base_frame <= '0;
        slot_page_count <= '0;
        slot_host_base <= '0;
        walk_root <= '0;
        walk_address <= '0;
        read_data <= '0;
        read_error <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_root_miss();
        test_slot_extremes();
        test_full_walk();
        test_walk_abort();
        test_random_walks();
        wait_for_results();
        repeat (2 * SLOTS + 8) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
